[rtl/core/m3inv_pkg.sv]
// Shared constants for the 3x3 matrix inverse block.
// No dependencies.
`default_nettype none
package m3inv_pkg;
  localparam int THR_W = 31;
  localparam int NUM_ELEM = 9;
  localparam logic [1:0] ADDR_DET_THRESHOLD = 2'd0;
endpackage
`default_nettype wire

[rtl/core/matrix3x3_inverse.sv]
// Pipelined 3x3 matrix inverse: adjugate, determinant, restoring divider.
// Depends on m3inv_pkg.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+----------------------
//   input    | in_m00 .. in_m22                       | start & !busy
//   result   | out_inv00 .. out_inv22, out_singular,  | out_valid, one cycle
//            | out_saturated                          |
//   config   | psel penable pwrite paddr pwdata       | APB, pready always high
//
// Products, cofactors and determinant are computed in front stages, then
// come one divider stage per quotient bit and an output register. One
// beat enters every cycle; busy is always low.
// Reset clears the valid bits and sets det_threshold to 1.
`default_nettype none
module matrix3x3_inverse
  import m3inv_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire signed [ELEM_WIDTH-1:0] in_m00,
  input  wire signed [ELEM_WIDTH-1:0] in_m01,
  input  wire signed [ELEM_WIDTH-1:0] in_m02,
  input  wire signed [ELEM_WIDTH-1:0] in_m10,
  input  wire signed [ELEM_WIDTH-1:0] in_m11,
  input  wire signed [ELEM_WIDTH-1:0] in_m12,
  input  wire signed [ELEM_WIDTH-1:0] in_m20,
  input  wire signed [ELEM_WIDTH-1:0] in_m21,
  input  wire signed [ELEM_WIDTH-1:0] in_m22,
  output logic                        out_valid,
  output logic signed [ELEM_WIDTH-1:0] out_inv00,
  output logic signed [ELEM_WIDTH-1:0] out_inv01,
  output logic signed [ELEM_WIDTH-1:0] out_inv02,
  output logic signed [ELEM_WIDTH-1:0] out_inv10,
  output logic signed [ELEM_WIDTH-1:0] out_inv11,
  output logic signed [ELEM_WIDTH-1:0] out_inv12,
  output logic signed [ELEM_WIDTH-1:0] out_inv20,
  output logic signed [ELEM_WIDTH-1:0] out_inv21,
  output logic signed [ELEM_WIDTH-1:0] out_inv22,
  output logic                        out_singular,
  output logic                        out_saturated,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [1:0]                  paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  localparam int E    = ELEM_WIDTH;
  localparam int PW   = 2 * E;
  localparam int CW   = 2 * E + 1;
  localparam int PPW  = 2 * E + 1;
  localparam int DW   = 3 * E + 3;
  localparam int NW   = 2 * E + 2 * FRAC_BITS;
  localparam int QB   = E + 1;
  localparam int CMPW = DW + NW + THR_W;

  logic [THR_W-1:0] thr_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_DET_THRESHOLD);
  assign prdata = (paddr == ADDR_DET_THRESHOLD) ? {1'b0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (wr_en) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  logic signed [E-1:0] m_in [3][3];
  assign m_in[0][0] = in_m00;
  assign m_in[0][1] = in_m01;
  assign m_in[0][2] = in_m02;
  assign m_in[1][0] = in_m10;
  assign m_in[1][1] = in_m11;
  assign m_in[1][2] = in_m12;
  assign m_in[2][0] = in_m20;
  assign m_in[2][1] = in_m21;
  assign m_in[2][2] = in_m22;

  // stage valids: 1..5 front, divider 0..QB, output
  logic             v1_r, v2_r, v3_r, v4_r;
  logic             dv_r [QB+1];

  logic signed [PW-1:0]  prod_r [NUM_ELEM][2];
  logic signed [E-1:0]   row2_r1 [3];
  logic signed [E-1:0]   row2_r2 [3];
  logic signed [CW-1:0]  cof_r2 [NUM_ELEM];
  logic signed [CW-1:0]  cof_r3 [NUM_ELEM];
  logic signed [CW-1:0]  cof_r4 [NUM_ELEM];
  logic signed [PPW-1:0] plo_r [3];
  logic signed [PPW-1:0] phi_r [3];
  logic signed [DW-1:0]  det_r;

  logic [DW-1:0] rem_r  [QB+1][NUM_ELEM];
  logic [QB-1:0] qsh_r  [QB+1][NUM_ELEM];
  logic          neg_r  [QB+1][NUM_ELEM];
  logic          ovf_r  [QB+1][NUM_ELEM];
  logic [DW-1:0] adet_r [QB+1];
  logic          sing_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  genvar gi, gc, gk;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_row
      for (gc = 0; gc < 3; gc++) begin : g_col
        always_ff @(posedge clk) begin
          prod_r[3*gi+gc][0] <= m_in[(gi+1)%3][(gc+1)%3] * m_in[(gi+2)%3][(gc+2)%3];
          prod_r[3*gi+gc][1] <= m_in[(gi+1)%3][(gc+2)%3] * m_in[(gi+2)%3][(gc+1)%3];
          cof_r2[3*gi+gc]    <= CW'(prod_r[3*gi+gc][0]) - CW'(prod_r[3*gi+gc][1]);
          cof_r3[3*gi+gc]    <= cof_r2[3*gi+gc];
          cof_r4[3*gi+gc]    <= cof_r3[3*gi+gc];
        end
      end
    end

    for (gc = 0; gc < 3; gc++) begin : g_det
      always_ff @(posedge clk) begin
        row2_r1[gc] <= m_in[2][gc];
        row2_r2[gc] <= row2_r1[gc];
        plo_r[gc]   <= PPW'($signed({1'b0, cof_r2[6+gc][E-1:0]}) * row2_r2[gc]);
        phi_r[gc]   <= PPW'($signed(cof_r2[6+gc][CW-1:E]) * row2_r2[gc]);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    det_r <= DW'(plo_r[0]) + DW'(plo_r[1]) + DW'(plo_r[2])
           + (DW'(phi_r[0]) <<< E) + (DW'(phi_r[1]) <<< E) + (DW'(phi_r[2]) <<< E);
  end

  logic [DW-1:0]   adet_nxt;
  logic [CMPW-1:0] bound;
  logic            sing_nxt;
  assign adet_nxt = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
  assign bound    = CMPW'(thr_r) << (2 * FRAC_BITS);
  assign sing_nxt = (adet_nxt == '0) || (CMPW'(adet_nxt) < bound);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v4_r;
    end
    adet_r[0] <= adet_nxt;
    sing_r[0] <= sing_nxt;
  end

  generate
    for (gi = 0; gi < 3; gi++) begin : g_oi
      for (gc = 0; gc < 3; gc++) begin : g_oj
        // inverse (i,j) takes cofactor (j,i)
        logic [PW-1:0] acof;
        logic [NW-1:0] num_abs;
        logic [NW-1:0] num_hi;
        assign acof    = cof_r4[3*gc+gi][CW-1] ? PW'(-cof_r4[3*gc+gi])
                                                : PW'(cof_r4[3*gc+gi]);
        assign num_abs = NW'(acof) << (2 * FRAC_BITS);
        assign num_hi  = num_abs >> QB;
        always_ff @(posedge clk) begin
          rem_r[0][3*gi+gc] <= DW'(num_hi);
          qsh_r[0][3*gi+gc] <= num_abs[QB-1:0];
          neg_r[0][3*gi+gc] <= cof_r4[3*gc+gi][CW-1] ^ det_r[DW-1];
          ovf_r[0][3*gi+gc] <= CMPW'(num_hi) >= CMPW'(adet_nxt);
        end
      end
    end

    for (gk = 0; gk < QB; gk++) begin : g_div
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[gk+1] <= 1'b0;
        end else begin
          dv_r[gk+1] <= dv_r[gk];
        end
        adet_r[gk+1] <= adet_r[gk];
        sing_r[gk+1] <= sing_r[gk];
      end
      for (gi = 0; gi < NUM_ELEM; gi++) begin : g_lane
        logic [DW:0] trial;
        logic        take;
        assign trial = {rem_r[gk][gi], qsh_r[gk][gi][QB-1]};
        assign take  = trial >= {1'b0, adet_r[gk]};
        always_ff @(posedge clk) begin
          rem_r[gk+1][gi] <= take ? DW'(trial - {1'b0, adet_r[gk]}) : DW'(trial);
          qsh_r[gk+1][gi] <= {qsh_r[gk][gi][QB-2:0], take};
          neg_r[gk+1][gi] <= neg_r[gk][gi];
          ovf_r[gk+1][gi] <= ovf_r[gk][gi];
        end
      end
    end
  endgenerate

  logic signed [E-1:0] res_nxt [NUM_ELEM];
  logic [NUM_ELEM-1:0] sat_vec;
  logic signed [E-1:0] res_r [NUM_ELEM];
  logic                sat_r, sing_out_r, out_v_r;

  generate
    for (gi = 0; gi < NUM_ELEM; gi++) begin : g_fin
      logic [DW:0]   rem2;
      logic [QB:0]   qr;
      logic          sat_e;
      localparam logic [QB:0] LIM = (QB+1)'(1) << (E - 1);
      assign rem2  = {rem_r[QB][gi], 1'b0};
      assign qr    = (QB+1)'(qsh_r[QB][gi]) + (QB+1)'(rem2 >= {1'b0, adet_r[QB]});
      assign sat_e = ovf_r[QB][gi] || (neg_r[QB][gi] ? (qr > LIM) : (qr >= LIM));
      assign sat_vec[gi] = sat_e && !sing_r[QB];
      always_comb begin
        if (sing_r[QB]) begin
          res_nxt[gi] = '0;
        end else if (sat_e) begin
          res_nxt[gi] = neg_r[QB][gi] ? E'(-LIM) : E'(LIM - 1'b1);
        end else begin
          res_nxt[gi] = neg_r[QB][gi] ? E'(-qr) : E'(qr);
        end
      end
      always_ff @(posedge clk) begin
        res_r[gi] <= res_nxt[gi];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= dv_r[QB];
    end
    sat_r      <= |sat_vec;
    sing_out_r <= sing_r[QB];
  end

  assign out_valid     = out_v_r;
  assign out_inv00     = res_r[0];
  assign out_inv01     = res_r[1];
  assign out_inv02     = res_r[2];
  assign out_inv10     = res_r[3];
  assign out_inv11     = res_r[4];
  assign out_inv12     = res_r[5];
  assign out_inv20     = res_r[6];
  assign out_inv21     = res_r[7];
  assign out_inv22     = res_r[8];
  assign out_singular  = sing_out_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv00 == '0 && out_inv11 == '0 && out_inv22 == '0
      && out_inv01 == '0 && out_inv12 == '0 && out_inv20 == '0)
    else $error("singular beat with nonzero element");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_singular && out_saturated))
    else $error("singular and saturated together");
  a_div_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[QB] |-> $past(dv_r[0], QB))
    else $error("divider valid lost or invented");
`endif
endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking bench for matrix3x3_inverse: random and directed matrices
// against an exact wide-integer inverse with rounding and saturation.
// Depends on m3inv_pkg and the matrix3x3_inverse RTL.
module testbench;
  import m3inv_pkg::*;

  typedef logic signed [31:0]  elem_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    elem_t inv[NUM_ELEM];
    bit    singular;
    bit    saturated;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t    pending_q[$];
    logic [30:0] threshold;
    int          mismatches;
    int          matrices;
    int          singular_seen;
    int          saturated_seen;

    function new();
      threshold = 1;
    endfunction

    function inverse_t invert(elem_t m[NUM_ELEM]);
      wide_t    x[9];
      wide_t    cof[9];
      wide_t    det, adet, num, anum, q, r, bound;
      bit       neg;
      inverse_t e;
      int       a, b;
      for (int k = 0; k < 9; k++) x[k] = m[k];
      for (int k = 0; k < 3; k++) begin
        a = (k + 1) % 3;
        b = (k + 2) % 3;
        for (int n = 0; n < 3; n++)
          cof[3*k+n] = x[3*a+(n+1)%3] * x[3*b+(n+2)%3]
                     - x[3*a+(n+2)%3] * x[3*b+(n+1)%3];
      end
      det = cof[6] * x[6] + cof[7] * x[7] + cof[8] * x[8];
      adet = (det < 0) ? -det : det;
      bound = wide_t'({225'd0, threshold}) <<< 32;
      e.saturated = 0;
      if (det == 0 || adet < bound) begin
        foreach (e.inv[k]) e.inv[k] = '0;
        e.singular = 1;
        return e;
      end
      e.singular = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          num  = cof[3*j+i] <<< 32;
          neg  = (num < 0) != (det < 0);
          anum = (num < 0) ? -num : num;
          q = anum / adet;
          r = anum % adet;
          if (r >= adet - r) q = q + 1;
          if (neg) begin
            if (q > 256'sh8000_0000) begin
              e.saturated = 1;
              e.inv[3*i+j] = 32'sh8000_0000;
            end else e.inv[3*i+j] = elem_t'(-q);
          end else begin
            if (q >= 256'sh8000_0000) begin
              e.saturated = 1;
              e.inv[3*i+j] = 32'sh7FFF_FFFF;
            end else e.inv[3*i+j] = elem_t'(q);
          end
        end
      return e;
    endfunction

    function void note_matrix(elem_t m[NUM_ELEM]);
      inverse_t e;
      e = invert(m);
      matrices++;
      if (e.singular) singular_seen++;
      if (e.saturated) saturated_seen++;
      pending_q.push_back(e);
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
    endfunction

    function void check_result(inverse_t got);
      inverse_t e;
      if (pending_q.size() == 0) begin
        report("unexpected beat, singular", 0, got.singular);
        return;
      end
      e = pending_q.pop_front();
      foreach (e.inv[k])
        if (e.inv[k] !== got.inv[k]) report($sformatf("inv%0d%0d", k / 3, k % 3),
                                            e.inv[k], got.inv[k]);
      if (e.singular !== got.singular) report("singular", e.singular, got.singular);
      if (e.saturated !== got.saturated) report("saturated", e.saturated, got.saturated);
    endfunction
  endclass

  logic        clk, rst_n, start;
  logic        busy, out_valid, out_singular, out_saturated, pready;
  elem_t       in_m[NUM_ELEM];
  elem_t       out_inv[NUM_ELEM];
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;

  inverse_scoreboard sb;

  matrix3x3_inverse dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid),
    .out_inv00(out_inv[0]), .out_inv01(out_inv[1]), .out_inv02(out_inv[2]),
    .out_inv10(out_inv[3]), .out_inv11(out_inv[4]), .out_inv12(out_inv[5]),
    .out_inv20(out_inv[6]), .out_inv21(out_inv[7]), .out_inv22(out_inv[8]),
    .out_singular(out_singular), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    inverse_t got;
    if (rst_n && out_valid) begin
      foreach (got.inv[k]) got.inv[k] = out_inv[k];
      got.singular  = out_singular;
      got.saturated = out_saturated;
      sb.check_result(got);
    end
  end

  int burst_mode;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode != 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_matrix(elem_t m[NUM_ELEM]);
    int gap;
    foreach (in_m[k]) in_m[k] <= m[k];
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_matrix(m);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    start <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task write_threshold(logic [30:0] thr);
    psel    <= 1;
    pwrite  <= 1;
    penable <= 0;
    paddr   <= ADDR_DET_THRESHOLD;
    pwdata  <= {1'b0, thr};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel    <= 0;
    penable <= 0;
    sb.threshold = thr;
  endtask

  function elem_t small_elem();
    return elem_t'($urandom_range(0, 8 << 16)) - elem_t'(4 << 16);
  endfunction

  task random_matrix(output elem_t m[NUM_ELEM]);
    int    mode;
    elem_t t;
    mode = $urandom_range(0, 9);
    foreach (m[k]) m[k] = (mode < 2) ? elem_t'($urandom) : small_elem();
    if (mode == 2) foreach (m[k]) m[k] = elem_t'($urandom_range(0, 64)) - 32;
    if (mode == 3 || mode == 4) begin
      // near-singular: third row close to the sum of the first two
      for (int c = 0; c < 3; c++) begin
        t = m[c] + m[3+c];
        m[6+c] = t + elem_t'($urandom_range(0, 6)) - 3;
      end
    end
    if (mode == 5) foreach (m[k]) if ($urandom_range(0, 2) == 0) m[k] = '0;
  endtask

  task directed_set();
    elem_t m[NUM_ELEM];
    elem_t one, mx, mn;
    one = 32'sh0001_0000;
    mx  = 32'sh7FFF_FFFF;
    mn  = 32'sh8000_0000;
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};              send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                    send_matrix(m);
    m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};                 send_matrix(m);
    m = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};                 send_matrix(m);
    m = '{mn, mx, mn, mx, mn, mx, mn, mx, mx};           send_matrix(m);
    m = '{-one, 0, 0, 0, one, 0, 0, 0, -one};            send_matrix(m);
    m = '{3 * one, 0, 0, 0, 3 * one, 0, 0, 0, 3 * one};  send_matrix(m);
    m = '{2 * one, one, 0, one, 2 * one, one, 0, one, 2 * one}; send_matrix(m);
    m = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
          7 * one, 8 * one, 9 * one};                    send_matrix(m);
    m = '{0, one, 0, one, 0, 0, 0, 0, one};              send_matrix(m);
    m = '{256, 0, 0, 0, 256, 0, 0, 0, 256};              send_matrix(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};           send_matrix(m);
    m = '{2, 0, 0, 0, 2, 0, 0, 0, 2};                    send_matrix(m);
  endtask

  initial begin
    elem_t       m[NUM_ELEM];
    logic [30:0] thr_list[6];
    sb = new();
    rst_n = 0;
    start = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    burst_mode = 0;
    foreach (in_m[k]) in_m[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    thr_list = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'd0, 31'd1};
    thr_list[3] = 31'($urandom_range(1, 1 << 20));
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        write_threshold(thr_list[ph]);
      end
      directed_set();
      for (int n = 0; n < 190; n++) begin
        if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        random_matrix(m);
        send_matrix(m);
      end
    end
    drain();
    $display("Checked %0d matrices over 6 threshold settings: %0d singular, %0d saturated.",
             sb.matrices, sb.singular_seen, sb.saturated_seen);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/m3inv_pkg.sv
rtl/core/matrix3x3_inverse.sv
dv/testbench.sv
